[src/jsed_pkg.sv]
// ----------------------------------------------------------------------------
// jsed_pkg
// types, codes and constants shared by the jis/sjis to euc decoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package jsed_pkg;

   // queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHAR_ESC      = 8'h1b;
   localparam logic [7:0] CHAR_LF       = 8'h0a;
   localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHAR_PAREN    = 8'h28;
   localparam logic [7:0] CHAR_QUESTION = 8'h3f;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] HIGH_BIT      = 8'h80;
   localparam logic [7:0] KANA_LOW      = 8'ha0;
   localparam logic [7:0] SJIS_HIGH     = 8'he0;

   // kanji range limits
   localparam logic [15:0] EUC_BAD_CODE  = 16'ha2a3;
   localparam logic [15:0] EUC_MIN       = 16'ha100;
   localparam logic [15:0] EUC_GAP_LOW   = 16'ha900;
   localparam logic [15:0] EUC_GAP_HIGH  = 16'hafff;
   localparam logic [15:0] EUC_LIMIT     = 16'hf500;
   localparam logic [15:0] EUC_PAIR_MASK = 16'h8080;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_ESC = 2'd1;
   localparam logic [1:0] STATUS_KANA    = 2'd2;

   // input code register values
   localparam logic INPUT_JIS_EUC = 1'b0;

   typedef enum logic [1:0] {
      MODE_ASCII  = 2'd0,
      MODE_KFIRST = 2'd1,
      MODE_KANJI  = 2'd2,
      MODE_APAIR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ESC_NONE    = 2'd0,
      ESC_SEEN    = 2'd1,
      ESC_SWALLOW = 2'd2
   } esc_type;

   typedef enum logic [1:0] {
      CMD_SINGLE    = 2'd0,
      CMD_EUC_PAIR  = 2'd1,
      CMD_SJIS_PAIR = 2'd2
   } cmd_kind_type;

   // one queued command from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   hi_byte;
      logic [7:0]   lo_byte;
      logic         line_end;
      logic [1:0]   status;
   } cmd_type;

endpackage

`default_nettype wire

[src/jsed_front.sv]
// ----------------------------------------------------------------------------
// jsed_front
// accepts input bytes, tracks escape and kanji mode, issues commands
// ----------------------------------------------------------------------------
`default_nettype none

module jsed_front
   import jsed_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_fire,
   input  wire logic [7:0] req_byte,
   input  wire logic       input_code,
   output logic            push,
   output cmd_type         push_cmd
);

   mode_type   mode_ff, mode_in;
   esc_type    esc_ff, esc_in;
   logic [7:0] pend_ff, pend_in;
   logic       pair_start;

   // high byte that opens a pair in ascii mode
   always_comb begin
      if (input_code == INPUT_JIS_EUC) begin
         pair_start = req_byte[7];
      end else begin
         pair_start = (req_byte >= SJIS_HIGH) || (req_byte[7] && (req_byte < KANA_LOW));
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      esc_in  = esc_ff;
      pend_in = pend_ff;
      if (req_fire) begin
         case (esc_ff)
            ESC_SEEN: begin
               if (req_byte == CHAR_DOLLAR) begin
                  mode_in = MODE_KANJI;
                  esc_in  = ESC_SWALLOW;
               end else if (req_byte == CHAR_PAREN) begin
                  mode_in = MODE_ASCII;
                  esc_in  = ESC_SWALLOW;
               end else begin
                  esc_in = ESC_NONE;
               end
            end
            ESC_SWALLOW: begin
               esc_in = ESC_NONE;
            end
            default: begin
               esc_in = ESC_NONE;
               if (req_byte != CHAR_LF) begin
                  case (mode_ff)
                     MODE_ASCII: begin
                        if (req_byte == CHAR_ESC) begin
                           esc_in = ESC_SEEN;
                        end else if (pair_start) begin
                           pend_in = req_byte;
                           mode_in = MODE_APAIR;
                        end
                     end
                     MODE_KFIRST: begin
                        mode_in = MODE_KANJI;
                     end
                     MODE_KANJI: begin
                        if (req_byte == CHAR_ESC) begin
                           esc_in = ESC_SEEN;
                        end else if (req_byte >= CHAR_SPACE) begin
                           pend_in = req_byte;
                           mode_in = MODE_KFIRST;
                        end
                     end
                     default: begin
                        mode_in = MODE_ASCII;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   // command issue
   always_comb begin
      push              = 1'b0;
      push_cmd.kind     = CMD_SINGLE;
      push_cmd.hi_byte  = pend_ff;
      push_cmd.lo_byte  = req_byte;
      push_cmd.line_end = 1'b0;
      push_cmd.status   = STATUS_OK;
      if (req_fire) begin
         case (esc_ff)
            ESC_SEEN: begin
               if ((req_byte != CHAR_DOLLAR) && (req_byte != CHAR_PAREN)) begin
                  push             = 1'b1;
                  push_cmd.lo_byte = 8'h00;
                  push_cmd.status  = STATUS_BAD_ESC;
               end
            end
            ESC_SWALLOW: begin
               push = 1'b0;
            end
            default: begin
               if (req_byte == CHAR_LF) begin
                  push              = 1'b1;
                  push_cmd.lo_byte  = 8'h00;
                  push_cmd.line_end = 1'b1;
               end else begin
                  case (mode_ff)
                     MODE_ASCII: begin
                        if ((req_byte != CHAR_ESC) && !pair_start) begin
                           push = 1'b1;
                           if (req_byte[7]) begin
                              push_cmd.lo_byte = CHAR_QUESTION;
                              push_cmd.status  = STATUS_KANA;
                           end
                        end
                     end
                     MODE_KFIRST: begin
                        push             = 1'b1;
                        push_cmd.kind    = CMD_EUC_PAIR;
                        push_cmd.hi_byte = pend_ff | HIGH_BIT;
                        push_cmd.lo_byte = req_byte | HIGH_BIT;
                     end
                     MODE_KANJI: begin
                        push = (req_byte != CHAR_ESC) && (req_byte < CHAR_SPACE);
                     end
                     default: begin
                        push = 1'b1;
                        if (input_code == INPUT_JIS_EUC) begin
                           push_cmd.kind = CMD_EUC_PAIR;
                        end else begin
                           push_cmd.kind = CMD_SJIS_PAIR;
                        end
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ASCII;
         esc_ff  <= ESC_NONE;
         pend_ff <= 8'h00;
      end else begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire

[src/jsed_queue.sv]
// ----------------------------------------------------------------------------
// jsed_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module jsed_queue
   import jsed_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output cmd_type      head_cmd
);

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[src/jsed_back.sv]
// ----------------------------------------------------------------------------
// jsed_back
// converts queued commands into result bytes, one or two per command
// ----------------------------------------------------------------------------
`default_nettype none

module jsed_back
   import jsed_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire cmd_type head_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [7:0]   rsp_byte,
   output logic         rsp_line_end,
   output logic [1:0]   rsp_status,
   output logic         rsp_last
);

   logic        valid_ff, valid_in;
   logic        second_ff, second_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  byte_ff, byte_in;
   logic        line_end_ff, line_end_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;
   logic        out_free;
   logic [7:0]  sj_h, sj_hi, sj_lo;
   logic [15:0] raw_code, fixed_code;

   // shift jis pair to euc
   always_comb begin
      sj_h  = head_cmd.hi_byte - ((head_cmd.hi_byte >= KANA_LOW) ? 8'hc1 : 8'h81);
      sj_hi = {sj_h[6:0], 1'b0} + 8'h21;
      if (head_cmd.lo_byte >= 8'h9f) begin
         sj_hi = sj_hi + 8'h01;
         sj_lo = head_cmd.lo_byte - 8'h7e;
      end else if (head_cmd.lo_byte <= 8'h7e) begin
         sj_lo = head_cmd.lo_byte - 8'h1f;
      end else begin
         sj_lo = head_cmd.lo_byte - 8'h20;
      end
   end

   // kanji range check
   always_comb begin
      if (head_cmd.kind == CMD_SJIS_PAIR) begin
         raw_code = {sj_hi, sj_lo} | EUC_PAIR_MASK;
      end else begin
         raw_code = {head_cmd.hi_byte, head_cmd.lo_byte};
      end
      if ((raw_code < EUC_MIN) || ((raw_code >= EUC_GAP_LOW) && (raw_code <= EUC_GAP_HIGH))
          || (raw_code >= EUC_LIMIT)) begin
         fixed_code = EUC_BAD_CODE;
      end else begin
         fixed_code = raw_code;
      end
   end

   assign out_free = !valid_ff || rsp_ready;
   assign pop      = out_free && !second_ff && !empty;

   always_comb begin
      valid_in    = valid_ff && !rsp_ready;
      second_in   = second_ff;
      lo_in       = lo_ff;
      byte_in     = byte_ff;
      line_end_in = line_end_ff;
      status_in   = status_ff;
      last_in     = last_ff;
      if (out_free && second_ff) begin
         valid_in    = 1'b1;
         second_in   = 1'b0;
         byte_in     = lo_ff;
         line_end_in = 1'b0;
         status_in   = STATUS_OK;
         last_in     = 1'b1;
      end else if (pop) begin
         valid_in = 1'b1;
         if (head_cmd.kind == CMD_SINGLE) begin
            byte_in     = head_cmd.lo_byte;
            line_end_in = head_cmd.line_end;
            status_in   = head_cmd.status;
            last_in     = 1'b1;
         end else begin
            second_in   = 1'b1;
            lo_in       = fixed_code[7:0];
            byte_in     = fixed_code[15:8];
            line_end_in = 1'b0;
            status_in   = STATUS_OK;
            last_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      byte_ff     <= byte_in;
      line_end_ff <= line_end_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_byte     = byte_ff;
   assign rsp_line_end = line_end_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

[src/jis_sjis_to_euc_decoder.sv]
// ----------------------------------------------------------------------------
// jis_sjis_to_euc_decoder
// byte-serial iso-2022-jp / euc-jp or shift jis text to euc-jp decoder
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_in_byte
//   rsp      out        rsp_valid / rsp_ready  rsp_out_byte, rsp_line_end,
//                                              rsp_status, rsp_last
//   csr      in         csr_valid / csr_ready  csr_input_code
//
// one input transaction per cycle while the command queue is not full; a byte
// that completes a pair yields two result transactions, set by the single output
// register, the second offered once the first is taken; the first result passes
// through a queue entry, then the output register
// synchronous active-high reset clears mode, escape state, queue and output
// req_ready drops only when the two-entry command queue is full, so the front
// keeps taking bytes while a result waits in the output register
//
`default_nettype none

module jis_sjis_to_euc_decoder
   import jsed_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_line_end,
   output logic [1:0]      rsp_status,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_input_code
);

   logic    input_code_ff;  // 0 jis/euc, 1 shift jis
   logic    req_fire;
   logic    push, pop, full, empty;
   cmd_type push_cmd, head_cmd;

   // register writes always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_code_ff <= INPUT_JIS_EUC;
      end else if (csr_valid) begin
         input_code_ff <= csr_input_code;
      end
   end

   // front accepts whenever the queue has room for a possible command
   assign req_ready = !full;
   assign req_fire  = req_valid && req_ready;

   jsed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_byte   (req_in_byte),
      .input_code (input_code_ff),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decouples classification from output stalls
   jsed_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head_cmd (head_cmd)
   );

   // pair conversion, range check and output register
   jsed_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_byte     (rsp_out_byte),
      .rsp_line_end (rsp_line_end),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

[src/jsed_checker.sv]
// ----------------------------------------------------------------------------
// jsed_checker
// port-level checks on the decoder results
// ----------------------------------------------------------------------------
`default_nettype none

module jsed_checker
   import jsed_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_line_end,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last
);

   // line end and bad escape carry no byte and end their input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_end || (rsp_status == STATUS_BAD_ESC))
         |-> (rsp_out_byte == 8'h00) && rsp_last)
      else $error("line end or bad escape result malformed");

   // replaced kana always shows as question mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_KANA) |-> (rsp_out_byte == CHAR_QUESTION) && rsp_last)
      else $error("kana replacement malformed");

   // first byte of a pair is followed at once by its last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("pair second byte not delivered");

   // a pair's first byte is a high byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_out_byte[7] && !rsp_line_end && (rsp_status == STATUS_OK))
      else $error("pair first byte malformed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind jis_sjis_to_euc_decoder jsed_checker u_jsed_checker (.*);

`default_nettype wire

[bench/euc_stream_checker.sv]
// ----------------------------------------------------------------------------
// euc_stream_checker
// watches the byte, result and csr channels of the jis/sjis to euc decoder,
// tracks the decode state itself and compares every result transaction
// ----------------------------------------------------------------------------
`default_nettype none

module euc_stream_checker
   import jsed_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_line_end,
   input  wire logic [1:0] rsp_status,
   input  wire logic       rsp_last,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic       csr_input_code,
   output int              mismatch_count,
   output int              pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] out_byte;
      logic       line_end;
      logic [1:0] status;
      logic       last;
   } euc_result_type;

   euc_result_type euc_expected[$];
   int             errors = 0;

   logic        code_sel;
   mode_type    mode;
   logic [7:0]  held_byte;
   esc_type     esc_state;

   function automatic logic [15:0] clamp_kanji_code(input logic [15:0] c);
      if (c < EUC_MIN || (c >= EUC_GAP_LOW && c <= EUC_GAP_HIGH) || c >= EUC_LIMIT)
         return EUC_BAD_CODE;
      return c;
   endfunction

   task automatic push_result(input logic [7:0] b, input logic le, input logic [1:0] st,
                              input logic lst);
      euc_result_type r;
      r.out_byte = b;
      r.line_end = le;
      r.status   = st;
      r.last     = lst;
      euc_expected.push_back(r);
   endtask

   task automatic push_pair(input logic [15:0] c);
      push_result(c[15:8], 1'b0, STATUS_OK, 1'b0);
      push_result(c[7:0], 1'b0, STATUS_OK, 1'b1);
   endtask

   task automatic decode_byte(input logic [7:0] b);
      logic [7:0] h;
      logic [7:0] hi;
      logic [7:0] lo;
      if (esc_state == ESC_SEEN) begin
         if (b == CHAR_DOLLAR) begin
            mode      = MODE_KANJI;
            esc_state = ESC_SWALLOW;
         end else if (b == CHAR_PAREN) begin
            mode      = MODE_ASCII;
            esc_state = ESC_SWALLOW;
         end else begin
            esc_state = ESC_NONE;
            push_result(8'h00, 1'b0, STATUS_BAD_ESC, 1'b1);
         end
      end else if (esc_state == ESC_SWALLOW) begin
         esc_state = ESC_NONE;
      end else begin
         esc_state = ESC_NONE;
         if (b == CHAR_LF) begin
            push_result(8'h00, 1'b1, STATUS_OK, 1'b1);
         end else begin
            case (mode)
               MODE_ASCII: begin
                  if (b == CHAR_ESC) begin
                     esc_state = ESC_SEEN;
                  end else if (code_sel == INPUT_JIS_EUC) begin
                     if (b[7]) begin
                        held_byte = b;
                        mode      = MODE_APAIR;
                     end else begin
                        push_result(b, 1'b0, STATUS_OK, 1'b1);
                     end
                  end else if (b >= SJIS_HIGH || (b >= HIGH_BIT && b < KANA_LOW)) begin
                     held_byte = b;
                     mode      = MODE_APAIR;
                  end else if (b < HIGH_BIT) begin
                     push_result(b, 1'b0, STATUS_OK, 1'b1);
                  end else begin
                     push_result(CHAR_QUESTION, 1'b0, STATUS_KANA, 1'b1);
                  end
               end
               MODE_KFIRST: begin
                  mode = MODE_KANJI;
                  push_pair(clamp_kanji_code({held_byte, b} | EUC_PAIR_MASK));
               end
               MODE_KANJI: begin
                  if (b == CHAR_ESC) begin
                     esc_state = ESC_SEEN;
                  end else if (b < CHAR_SPACE) begin
                     push_result(b, 1'b0, STATUS_OK, 1'b1);
                  end else begin
                     held_byte = b;
                     mode      = MODE_KFIRST;
                  end
               end
               default: begin
                  mode = MODE_ASCII;
                  if (code_sel == INPUT_JIS_EUC) begin
                     push_pair(clamp_kanji_code({held_byte, b}));
                  end else begin
                     // shift jis lead/trail to jis row/cell, then into euc
                     h  = held_byte - (held_byte >= KANA_LOW ? 8'hc1 : 8'h81);
                     hi = {h[6:0], 1'b0} + 8'h21;
                     if (b >= 8'h9f) begin
                        hi = hi + 8'h01;
                        lo = b - 8'h7e;
                     end else begin
                        lo = b - (b <= 8'h7e ? 8'h1f : 8'h20);
                     end
                     push_pair(clamp_kanji_code({hi, lo} | EUC_PAIR_MASK));
                  end
               end
            endcase
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      euc_result_type want;
      if (reset) begin
         code_sel  = INPUT_JIS_EUC;
         mode      = MODE_ASCII;
         held_byte = 8'h00;
         esc_state = ESC_NONE;
         euc_expected.delete();
      end else begin
         if (csr_valid && csr_ready)
            code_sel = csr_input_code;
         if (req_valid && req_ready)
            decode_byte(req_in_byte);
         if (rsp_valid && rsp_ready) begin
            if (euc_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual byte %0h le %0b st %0d",
                        $time, rsp_out_byte, rsp_line_end, rsp_status);
            end else begin
               want = euc_expected.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("line_end", 8'(want.line_end), 8'(rsp_line_end));
               check_field("status", 8'(want.status), 8'(rsp_status));
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
         end
      end
      pending_results <= euc_expected.size();
      mismatch_count  <= errors;
   end

endmodule

`default_nettype wire

[bench/jis_sjis_to_euc_decoder_test.sv]
// ----------------------------------------------------------------------------
// jis_sjis_to_euc_decoder_test
// drives byte streams through the decoder in both input codes, with random
// idling on both sides and one long result stall; the checker beside the
// block predicts every result and the verdict comes from its error count
// ----------------------------------------------------------------------------
`default_nettype none

module jis_sjis_to_euc_decoder_test;
   import jsed_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic INPUT_SJIS    = 1'b1;
   localparam int   PHASE_ITEMS   = 180;   // random bytes per phase
   localparam int   HOLD_CYCLES   = 300;   // long result stall
   localparam int   SETTLE_CYCLES = 8;     // pipeline is a queue entry, then the output register
   localparam int   QUIET_LIMIT   = 2000;  // cycles with no transaction at all

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_line_end;
   logic [1:0] rsp_status;
   logic       rsp_last;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic       csr_input_code = 1'b0;

   int mismatch_count;
   int pending_results;

   // idle rates in percent, switched per phase
   int req_idle_pct = 13;
   int rsp_idle_pct = 45;
   int sent_count   = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;
   bit hold_request = 1'b0;
   bit hold_started = 1'b0;

   // directed bytes, jis/euc input: plain ascii extremes, newline, kanji in and
   // out, control pass-through, newline inside a pending pair, esc completing
   // a pair, bad escape in kanji mode, newline as swallowed escape byte, euc
   // pairs above and below the kanji range
   logic [7:0] euc_directed[$] = '{
      8'h00, 8'h7f, CHAR_LF,
      CHAR_ESC, CHAR_DOLLAR, 8'h42,
      8'h30, 8'h21, 8'h0d, 8'h24, CHAR_LF, 8'h22, 8'h7f, CHAR_ESC,
      CHAR_ESC, CHAR_LF,
      CHAR_ESC, CHAR_PAREN, CHAR_LF,
      8'hff, 8'hff, 8'h80, 8'h00, 8'hb0
   };

   // directed bytes, shift jis input: trail byte at 0x9f, below 0x7f,
   // between 0x80 and 0x9e, single-byte kana, esc as trail byte, bad escape
   logic [7:0] sjis_directed[$] = '{
      8'ha1,
      8'h88, 8'h9f, 8'he0, 8'h40, 8'h81, 8'h80, 8'ha5,
      8'hff, CHAR_ESC, 8'h7f, CHAR_ESC, 8'h41
   };

   jis_sjis_to_euc_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_line_end   (rsp_line_end),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_input_code (csr_input_code)
   );

   euc_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_line_end    (rsp_line_end),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_input_code  (csr_input_code),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: random stalls, plus one long hold-off when asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_started) begin
         hold_started = 1'b1;
         hold_left    = HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog: any transaction on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one byte transaction, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // stop sending and wait until every predicted result has come back
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_code(input logic code);
      csr_valid      <= 1'b1;
      csr_input_code <= code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random text: mostly well-formed ascii, pairs and kanji runs,
   // with kana, bad escapes and plain noise mixed in
   task automatic run_phase(input logic code, input int req_pct, input int rsp_pct);
      int         first_sent;
      int         sel;
      int         runs;
      logic [7:0] lead;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      write_code(code);
      first_sent = sent_count;
      while (sent_count - first_sent < PHASE_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 30) begin
            send_byte(8'($urandom_range(0, 127)));
         end else if (sel < 35) begin
            send_byte(CHAR_LF);
         end else if (sel < 55) begin
            // two-byte code in ascii mode
            sel = $urandom_range(99);
            if (code == INPUT_JIS_EUC || sel >= 85)
               lead = 8'($urandom_range(128, 255));
            else if (sel < 50)
               lead = 8'($urandom_range(8'h81, 8'h9f));
            else
               lead = 8'($urandom_range(8'he0, 8'hfc));
            send_byte(lead);
            if ($urandom_range(3) == 0)
               send_byte(8'($urandom_range(0, 255)));
            else
               send_byte(8'($urandom_range(8'h40, 8'hfc)));
         end else if (sel < 80) begin
            // kanji run framed by escapes
            send_byte(CHAR_ESC);
            send_byte(CHAR_DOLLAR);
            send_byte(8'($urandom_range(1) ? 8'h42 : $urandom_range(0, 255)));
            runs = $urandom_range(1, 6);
            repeat (runs) begin
               if ($urandom_range(9) == 0) begin
                  send_byte(8'($urandom_range(0, 31)));
               end else begin
                  send_byte(8'($urandom_range(8'h21, 8'h7e)));
                  send_byte(8'($urandom_range(8'h21, 8'h7e)));
               end
            end
            send_byte(CHAR_ESC);
            send_byte(CHAR_PAREN);
            send_byte(8'($urandom_range(1) ? 8'h42 : $urandom_range(0, 255)));
         end else if (sel < 88) begin
            send_byte(8'($urandom_range(8'ha0, 8'hdf)));
         end else if (sel < 94) begin
            send_byte(CHAR_ESC);
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      settle_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, one pass per input code
      write_code(INPUT_JIS_EUC);
      foreach (euc_directed[i]) send_byte(euc_directed[i]);
      settle_idle();
      write_code(INPUT_SJIS);
      foreach (sjis_directed[i]) send_byte(sjis_directed[i]);
      settle_idle();

      // sender idles lightly, receiver heavily
      run_phase(INPUT_JIS_EUC, 13, 45);
      run_phase(INPUT_SJIS, 13, 45);
      // the other way round
      run_phase(INPUT_SJIS, 45, 13);
      run_phase(INPUT_JIS_EUC, 45, 13);
      // no idling; the long result stall lands here and backs up the input
      hold_request = 1'b1;
      run_phase(INPUT_JIS_EUC, 0, 0);
      run_phase(INPUT_SJIS, 0, 0);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
